/* hdl/pags_pkg.sv */
`default_nettype none
package pags_pkg;

	localparam int DEF_NUM_RESIDUES = 24;
	localparam int unsigned MAX_SEQ_LEN = 1048576;

	localparam int RES_W   = 5;
	localparam int ENTRY_W = 8;
	localparam int POS_W   = 20;
	localparam int PEN_W   = 8;
	localparam int SUM_W   = 32;

	// largest position after clamping to the sequence length
	localparam int unsigned POS_MAX = (MAX_SEQ_LEN > (2 ** POS_W)) ?
		((2 ** POS_W) - 1) : (MAX_SEQ_LEN - 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [PEN_W-1:0] GAP_OPEN_RESET   = 8'd11;
	localparam logic [PEN_W-1:0] GAP_EXTEND_RESET = 8'd1;

	typedef enum logic {
		REG_GAP_OPEN   = 1'b0,
		REG_GAP_EXTEND = 1'b1
	} pags_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PAIR = 1'b1
	} pags_op_t;

	typedef struct packed {
		pags_op_t                   op;
		logic [RES_W-1:0]           x_residue;
		logic [RES_W-1:0]           y_residue;
		logic signed [ENTRY_W-1:0]  entry_value;
		logic [POS_W-1:0]           x_pos;
		logic [POS_W-1:0]           y_pos;
		logic                       batch_start;
		logic                       last_pair;
	} pags_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] pair_score;
		logic signed [SUM_W-1:0] x_self_score;
		logic signed [SUM_W-1:0] y_self_score;
	} pags_result_t;

endpackage
`default_nettype wire

/* hdl/pags_if.sv */
`default_nettype none
interface pags_item_if;
	import pags_pkg::*;
	logic       valid;
	logic       ready;
	pags_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pags_result_if;
	import pags_pkg::*;
	logic         valid;
	logic         ready;
	pags_result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/protein_alignment_gap_scoring_core.sv */
// a last pair's result goes from stage 1 through stage 2 into the output register
// throughput: one request per cycle, loads and pairs alike; the only stall is a
// last pair that reaches the accumulators while the output register still holds
// an untaken result. matrix and diagonal read data arrive in the cycle after accept.
// reset: sums, gap tracking and valids clear, penalties return to 11 and 1;
// the substitution matrix is not cleared and holds garbage until loaded
`default_nettype none
module protein_alignment_gap_scoring_core #(
	parameter int NUM_RESIDUES = pags_pkg::DEF_NUM_RESIDUES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pags_item_if.sink                        items,
	pags_result_if.source                    results,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pags_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pags_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pags_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import pags_pkg::*;

	localparam int IDX_W     = (NUM_RESIDUES > 1) ? $clog2(NUM_RESIDUES) : 1;
	localparam int MAT_DEPTH = NUM_RESIDUES * NUM_RESIDUES;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);
	localparam int GAP_W     = POS_W + PEN_W + 1;
	localparam int ACC_W     = SUM_W + 2;
	localparam logic [RES_W:0] NUM_RES_C = (RES_W + 1)'(NUM_RESIDUES);
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	function automatic logic signed [SUM_W-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > ACC_W'(SUM_MAX))
			r = SUM_MAX;
		else if (v < ACC_W'(SUM_MIN))
			r = SUM_MIN;
		else
			r = v[SUM_W-1:0];
		return r;
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		if (32'(p) > POS_MAX)
			r = POS_W'(POS_MAX);
		else
			r = p;
		return r;
	endfunction

	// configuration registers
	logic [PEN_W-1:0] gap_open_q, gap_extend_q;
	pags_reg_t        reg_sel;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = pags_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q   <= GAP_OPEN_RESET;
			gap_extend_q <= GAP_EXTEND_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_GAP_OPEN:   gap_open_q   <= pwdata[PEN_W-1:0];
				REG_GAP_EXTEND: gap_extend_q <= pwdata[PEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GAP_OPEN:   prdata = APB_DATA_W'(gap_open_q);
			REG_GAP_EXTEND: prdata = APB_DATA_W'(gap_extend_q);
			default:        prdata = '0;
		endcase
	end

	// handshake and stall
	logic valid_s2, last_s2;
	logic stall, advance, accept, is_pair, is_load;

	assign stall   = valid_s2 && last_s2 && results.valid && !results.ready;
	assign advance = !stall;
	assign items.ready = advance;
	assign accept  = items.valid && advance;
	assign is_pair = accept && (items.data.op == OP_PAIR);
	assign is_load = accept && (items.data.op == OP_LOAD);

	// stage 0: address decode and gap cost
	logic             x_ok, y_ok;
	logic [IDX_W-1:0] x_idx, y_idx;
	logic [MAT_AW-1:0] mat_addr;

	assign x_ok  = {1'b0, items.data.x_residue} < NUM_RES_C;
	assign y_ok  = {1'b0, items.data.y_residue} < NUM_RES_C;
	assign x_idx = items.data.x_residue[IDX_W-1:0];
	assign y_idx = items.data.y_residue[IDX_W-1:0];
	assign mat_addr = MAT_AW'(MAT_AW'(y_idx) * MAT_AW'(NUM_RESIDUES)) + MAT_AW'(x_idx);

	logic [POS_W:0]   prior_x_end_q, prior_y_end_q;
	logic             have_prior_q;
	logic [POS_W-1:0] xp, yp;
	logic [POS_W:0]   jump_x, jump_y;
	logic             charge_x, charge_y;
	logic [GAP_W-1:0] cost_x, cost_y;

	assign xp = clamp_pos(items.data.x_pos);
	assign yp = clamp_pos(items.data.y_pos);
	assign jump_x = {1'b0, xp} - prior_x_end_q;
	assign jump_y = {1'b0, yp} - prior_y_end_q;
	assign charge_x = items.data.batch_start && have_prior_q && (prior_x_end_q < {1'b0, xp});
	assign charge_y = items.data.batch_start && have_prior_q && (prior_y_end_q < {1'b0, yp});
	assign cost_x = GAP_W'(gap_open_q) +
		GAP_W'(GAP_W'(jump_x[POS_W-1:0]) * GAP_W'(gap_extend_q));
	assign cost_y = GAP_W'(gap_open_q) +
		GAP_W'(GAP_W'(jump_y[POS_W-1:0]) * GAP_W'(gap_extend_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_x_end_q <= '0;
			prior_y_end_q <= '0;
			have_prior_q  <= 1'b0;
		end else if (is_pair) begin
			if (items.data.last_pair) begin
				prior_x_end_q <= '0;
				prior_y_end_q <= '0;
				have_prior_q  <= 1'b0;
			end else begin
				prior_x_end_q <= {1'b0, xp} + 1'b1;
				prior_y_end_q <= {1'b0, yp} + 1'b1;
				have_prior_q  <= 1'b1;
			end
		end
	end

	// matrix and diagonal memories, read data registered into stage 1
	logic signed [ENTRY_W-1:0] mat_mem  [MAT_DEPTH];
	logic signed [ENTRY_W-1:0] diag_mem [NUM_RESIDUES];
	logic signed [ENTRY_W-1:0] mat_rd_s1, diag_x_rd_s1, diag_y_rd_s1;

	always_ff @(posedge clk) begin
		if (is_load && x_ok && y_ok) begin
			mat_mem[mat_addr] <= items.data.entry_value;
			if (x_idx == y_idx)
				diag_mem[x_idx] <= items.data.entry_value;
		end
		if (is_pair) begin
			if (x_ok && y_ok)
				mat_rd_s1 <= mat_mem[mat_addr];
			if (x_ok)
				diag_x_rd_s1 <= diag_mem[x_idx];
			if (y_ok)
				diag_y_rd_s1 <= diag_mem[y_idx];
		end
	end

	// stage 1
	logic             valid_s1;
	logic             last_s1, xy_ok_s1, x_ok_s1, y_ok_s1;
	logic [GAP_W-1:0] cost_x_s1, cost_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= is_pair;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1   <= items.data.last_pair;
			xy_ok_s1  <= x_ok && y_ok;
			x_ok_s1   <= x_ok;
			y_ok_s1   <= y_ok;
			cost_x_s1 <= charge_x ? cost_x : '0;
			cost_y_s1 <= charge_y ? cost_y : '0;
		end
	end

	// stage 2: masked matrix values and combined gap cost
	logic signed [ENTRY_W-1:0] m_pair_s2, m_x_s2, m_y_s2;
	logic [GAP_W:0]            gap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s2   <= last_s1;
			m_pair_s2 <= xy_ok_s1 ? mat_rd_s1 : '0;
			m_x_s2    <= x_ok_s1 ? diag_x_rd_s1 : '0;
			m_y_s2    <= y_ok_s1 ? diag_y_rd_s1 : '0;
			// two subtractions from one sum saturate the same as their total
			gap_s2    <= {1'b0, cost_x_s1} + {1'b0, cost_y_s1};
		end
	end

	// accumulators
	logic signed [SUM_W-1:0] pair_sum_q, x_sum_q, y_sum_q;
	logic signed [SUM_W-1:0] pair_gapped, pair_next, x_next, y_next;
	logic                    finish;

	assign pair_gapped = sat(ACC_W'(pair_sum_q) - $signed(ACC_W'(gap_s2)));
	assign pair_next   = sat(ACC_W'(pair_gapped) + ACC_W'(m_pair_s2));
	assign x_next      = sat(ACC_W'(x_sum_q) + ACC_W'(m_x_s2));
	assign y_next      = sat(ACC_W'(y_sum_q) + ACC_W'(m_y_s2));
	assign finish      = advance && valid_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_sum_q <= '0;
			x_sum_q    <= '0;
			y_sum_q    <= '0;
		end else if (advance && valid_s2) begin
			if (last_s2) begin
				pair_sum_q <= '0;
				x_sum_q    <= '0;
				y_sum_q    <= '0;
			end else begin
				pair_sum_q <= pair_next;
				x_sum_q    <= x_next;
				y_sum_q    <= y_next;
			end
		end
	end

	// output register
	logic         out_valid_q;
	pags_result_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q.pair_score   <= pair_next;
			out_data_q.x_self_score <= x_next;
			out_data_q.y_self_score <= y_next;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	// a finished alignment leaves the accumulators at zero
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (pair_sum_q == '0) && (x_sum_q == '0) && (y_sum_q == '0))
		else $error("accumulators not cleared after last pair");

	// a last pair forgets the earlier batch
	a_prior_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(is_pair && items.data.last_pair) |=> !have_prior_q)
		else $error("gap tracking survived end of alignment");

	// a stalled last pair stays put until the output register frees
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> valid_s2 && last_s2 && results.valid)
		else $error("last pair dropped during stall");

	// a new result only lands once the previous one is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |=> results.valid && $stable(results.data))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

/* test/protein_alignment_gap_scoring_core_tb.sv */
`timescale 1ns / 100ps
module protein_alignment_gap_scoring_core_tb;
	import pags_pkg::*;

	localparam int NRES = DEF_NUM_RESIDUES;
	localparam longint S32_MAX = 2147483647;
	localparam longint S32_MIN = -S32_MAX - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	pags_item_if items_ch();
	pags_result_if results_ch();

	protein_alignment_gap_scoring_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// scoring state kept alongside the block
	logic signed [ENTRY_W-1:0] subst [NRES][NRES];
	bit written [NRES][NRES];
	logic [POS_W:0] prev_x_end;
	logic [POS_W:0] prev_y_end;
	bit seen_pair;
	longint acc_pair;
	longint acc_x;
	longint acc_y;
	logic [PEN_W-1:0] pen_open;
	logic [PEN_W-1:0] pen_extend;
	pags_result_t expected_scores[$];

	int err_count;
	int items_sent;
	int loads_sent;
	int scores_checked;
	int cycle_count;
	int long_hold_reqs;
	bit tx_gaps;
	bit rx_gaps;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("protein_alignment_gap_scoring_core test failed");
		$finish;
	end

	function automatic longint sat32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	function automatic longint cell_value(logic [RES_W-1:0] row, logic [RES_W-1:0] col);
		if (row >= NRES || col >= NRES)
			return 0;
		return longint'(subst[row][col]);
	endfunction

	// only a strictly forward jump is charged
	function automatic longint gap_charge(logic [POS_W:0] prior_end, logic [POS_W-1:0] pos);
		if (prior_end >= {1'b0, pos})
			return 0;
		return longint'(pen_open) + (longint'(pos) - longint'(prior_end)) * longint'(pen_extend);
	endfunction

	function automatic void clear_alignment();
		prev_x_end = '0;
		prev_y_end = '0;
		seen_pair = 1'b0;
		acc_pair = 0;
		acc_x = 0;
		acc_y = 0;
	endfunction

	function automatic void score_request(pags_item_t it);
		pags_result_t res;
		if (it.op == OP_LOAD) begin
			loads_sent++;
			if (it.x_residue < NRES && it.y_residue < NRES) begin
				subst[it.y_residue][it.x_residue] = it.entry_value;
				written[it.y_residue][it.x_residue] = 1'b1;
			end
			return;
		end
		// gap cost comes off before this pair's own value
		if (it.batch_start && seen_pair) begin
			acc_pair = sat32(acc_pair - gap_charge(prev_x_end, it.x_pos));
			acc_pair = sat32(acc_pair - gap_charge(prev_y_end, it.y_pos));
		end
		acc_x = sat32(acc_x + cell_value(it.x_residue, it.x_residue));
		acc_y = sat32(acc_y + cell_value(it.y_residue, it.y_residue));
		acc_pair = sat32(acc_pair + cell_value(it.y_residue, it.x_residue));
		prev_x_end = {1'b0, it.x_pos} + 1'b1;
		prev_y_end = {1'b0, it.y_pos} + 1'b1;
		seen_pair = 1'b1;
		if (it.last_pair) begin
			res.pair_score = acc_pair[SUM_W-1:0];
			res.x_self_score = acc_x[SUM_W-1:0];
			res.y_self_score = acc_y[SUM_W-1:0];
			expected_scores.push_back(res);
			clear_alignment();
		end
	endfunction

	function automatic void check_score(pags_result_t got);
		pags_result_t want;
		if (expected_scores.size() == 0) begin
			$error("score with none pending: pair_score %0d x_self_score %0d y_self_score %0d",
				got.pair_score, got.x_self_score, got.y_self_score);
			err_count++;
			return;
		end
		want = expected_scores.pop_front();
		scores_checked++;
		if (got.pair_score !== want.pair_score) begin
			$error("pair_score: expected %0d, got %0d", want.pair_score, got.pair_score);
			err_count++;
		end
		if (got.x_self_score !== want.x_self_score) begin
			$error("x_self_score: expected %0d, got %0d", want.x_self_score, got.x_self_score);
			err_count++;
		end
		if (got.y_self_score !== want.y_self_score) begin
			$error("y_self_score: expected %0d, got %0d", want.y_self_score, got.y_self_score);
			err_count++;
		end
	endfunction

	// result side: random stalls, plus a long hold when the test asks for one
	initial begin
		int unsigned hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				check_score(results_ch.data);
			if (long_hold_reqs != holds_seen) begin
				holds_seen = long_hold_reqs;
				hold_left = LONG_HOLD;
			end else if (hold_left == 0 && rx_gaps && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 17);
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	// called at a rising edge; returns at the edge where the request is taken
	task automatic push_item(input pags_item_t it);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.data <= it;
		do @(posedge clk); while (!items_ch.ready);
		score_request(it);
		items_sent++;
	endtask

	task automatic drain();
		items_ch.valid <= 1'b0;
		while (expected_scores.size() != 0)
			@(posedge clk);
		// loads and open pairs may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_reg(input pags_reg_t r, input logic [PEN_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_ADDR_W'(4 * int'(r));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(want)) begin
			$error("%s readback: expected %0d, got %0d", r.name(), want, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input pags_reg_t r, input logic [PEN_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * int'(r));
		pwdata <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (r == REG_GAP_OPEN)
			pen_open = val;
		else
			pen_extend = val;
		read_reg(r, val);
	endtask

	task automatic set_penalties(input logic [PEN_W-1:0] open_val, input logic [PEN_W-1:0] ext_val);
		drain();
		write_reg(REG_GAP_OPEN, open_val);
		write_reg(REG_GAP_EXTEND, ext_val);
	endtask

	function automatic pags_item_t pair_item(input logic [RES_W-1:0] x, y,
			input logic [POS_W-1:0] xp, yp, input logic bs, last);
		pags_item_t it;
		it = '0;
		it.op = OP_PAIR;
		it.x_residue = x;
		it.y_residue = y;
		it.x_pos = xp;
		it.y_pos = yp;
		it.batch_start = bs;
		it.last_pair = last;
		return it;
	endfunction

	function automatic logic [RES_W-1:0] pick_residue();
		if ($urandom_range(0, 11) == 0)
			return RES_W'($urandom_range(NRES, 31));
		return RES_W'($urandom_range(0, NRES - 1));
	endfunction

	task automatic load_entry(input logic [RES_W-1:0] row, col, input logic signed [ENTRY_W-1:0] v);
		pags_item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.y_residue = row;
		it.x_residue = col;
		it.entry_value = v;
		push_item(it);
	endtask

	// never let a pair read a matrix entry that was not loaded
	task automatic ensure_entries(input logic [RES_W-1:0] x, y);
		if (x < NRES && !written[x][x])
			load_entry(x, x, ENTRY_W'($urandom));
		if (y < NRES && !written[y][y])
			load_entry(y, y, ENTRY_W'($urandom));
		if (x < NRES && y < NRES && !written[y][x])
			load_entry(y, x, ENTRY_W'($urandom));
	endtask

	task automatic send_alignment();
		int unsigned batches;
		int unsigned len;
		logic [POS_W-1:0] xp;
		logic [POS_W-1:0] yp;
		logic [RES_W-1:0] xr;
		logic [RES_W-1:0] yr;
		batches = $urandom_range(1, 4);
		xp = POS_W'($urandom_range(0, 1040000));
		yp = POS_W'($urandom_range(0, 1040000));
		for (int b = 0; b < batches; b++) begin
			len = $urandom_range(1, 5);
			if (b > 0) begin
				xp += POS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) :
					$urandom_range(0, 12));
				yp += POS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) :
					$urandom_range(0, 12));
			end
			for (int k = 0; k < len; k++) begin
				xr = pick_residue();
				yr = pick_residue();
				ensure_entries(xr, yr);
				push_item(pair_item(xr, yr, xp, yp, k == 0, b == batches - 1 && k == len - 1));
				xp++;
				yp++;
			end
		end
	endtask

	task automatic send_noise();
		logic [63:0] raw;
		pags_item_t it;
		raw = {$urandom, $urandom};
		it = raw[$bits(pags_item_t)-1:0];
		it.last_pair = ($urandom_range(0, 3) == 0);
		if (it.op == OP_PAIR)
			ensure_entries(it.x_residue, it.y_residue);
		push_item(it);
	endtask

	task automatic test_reset_registers();
		read_reg(REG_GAP_OPEN, GAP_OPEN_RESET);
		read_reg(REG_GAP_EXTEND, GAP_EXTEND_RESET);
	endtask

	// runs on the reset penalties
	task automatic test_directed_cases();
		load_entry(0, 0, 8'sd127);
		load_entry(NRES - 1, NRES - 1, -8'sd128);
		load_entry(0, NRES - 1, -8'sd128);
		load_entry(NRES - 1, 0, 8'sd127);
		// codes past the table: ignored
		load_entry(NRES, 0, 8'sd99);
		load_entry(31, 31, -8'sd1);
		push_item(pair_item(0, 0, 0, 0, 1'b1, 1'b0));
		push_item(pair_item(NRES - 1, 0, 1, 1, 1'b0, 1'b0));
		// forward jump in both sequences
		push_item(pair_item(0, NRES - 1, 10, 5, 1'b1, 1'b0));
		// backward jump, x code out of range
		push_item(pair_item(NRES, NRES - 1, 2, 0, 1'b1, 1'b0));
		// zero jump, both codes out of range
		push_item(pair_item(31, 31, 3, 1, 1'b1, 1'b1));
		// batch start with nothing before it
		push_item(pair_item(0, NRES - 1, POS_MAX, POS_MAX, 1'b1, 1'b1));
		drain();
	endtask

	task automatic test_gap_saturation();
		logic [POS_W-1:0] pos;
		set_penalties(8'd255, 8'd255);
		for (int k = 0; k < 12; k++) begin
			pos = (k % 2 == 0) ? '0 : POS_W'(POS_MAX);
			push_item(pair_item(0, 0, pos, pos, 1'b1, 1'b0));
		end
		// backward jump is free, so the score steps up off the floor
		push_item(pair_item(0, 0, 0, 0, 1'b1, 1'b1));
		drain();
	endtask

	task automatic test_backpressure();
		logic [RES_W-1:0] xr;
		logic [RES_W-1:0] yr;
		set_penalties(PEN_W'($urandom), PEN_W'($urandom));
		tx_gaps = 1'b0;
		long_hold_reqs <= long_hold_reqs + 1;
		for (int k = 0; k < 40; k++) begin
			xr = pick_residue();
			yr = pick_residue();
			ensure_entries(xr, yr);
			push_item(pair_item(xr, yr, POS_W'($urandom), POS_W'($urandom), 1'b1, 1'b1));
		end
		// sender waits for every score before going on
		drain();
	endtask

	task automatic test_random_alignments(input int n, input logic [PEN_W-1:0] open_val,
			input logic [PEN_W-1:0] ext_val, input bit gaps_on);
		int first;
		int unsigned pick;
		set_penalties(open_val, ext_val);
		rx_gaps = gaps_on;
		first = items_sent;
		while (items_sent - first < n) begin
			tx_gaps = gaps_on && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_alignment();
			else if (pick == 7)
				load_entry(pick_residue(), pick_residue(), ENTRY_W'($urandom));
			else
				send_noise();
		end
		drain();
	endtask

	initial begin
		err_count = 0;
		items_sent = 0;
		loads_sent = 0;
		scores_checked = 0;
		long_hold_reqs = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		pen_open = GAP_OPEN_RESET;
		pen_extend = GAP_EXTEND_RESET;
		clear_alignment();
		arst_n <= 1'b0;
		items_ch.valid <= 1'b0;
		items_ch.data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_registers();
		test_directed_cases();
		test_gap_saturation();
		test_backpressure();
		test_random_alignments(100, 8'd0, 8'd0, 1'b1);
		test_random_alignments(100, 8'd255, 8'd0, 1'b1);
		test_random_alignments(100, 8'd0, 8'd255, 1'b1);
		test_random_alignments(100, PEN_W'($urandom), PEN_W'($urandom), 1'b0);

		$display("%0d requests sent (%0d matrix loads), %0d scores checked", items_sent,
			loads_sent, scores_checked);
		$display("gap penalties from 0 to 255, saturation, and a long output hold were exercised");
		if (err_count == 0)
			$display("protein_alignment_gap_scoring_core test passed");
		else
			$display("protein_alignment_gap_scoring_core test failed");
		$finish;
	end

endmodule

/* protein_alignment_gap_scoring_core.f */
hdl/pags_pkg.sv
hdl/pags_if.sv
hdl/protein_alignment_gap_scoring_core.sv
test/protein_alignment_gap_scoring_core_tb.sv
